/* src/trjf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trjf_pkg: shared types and constants
// Report layout constants, the decoded report record and the queue depth.
// ----------------------------------------------------------------------------
package trjf_pkg;

    localparam int COORD_W     = 12;
    localparam int PRESS_W     = 8;
    localparam int FRAME_W     = 64;
    localparam int S_TDATA_W   = 2 * FRAME_W;
    localparam int M_TDATA_W   = 4 * COORD_W + 2 * PRESS_W;

    // Coordinates are kept to this many bits.
    localparam int COORD_BITS  = 12;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

    localparam logic [7:0] NIB_LO_MASK = 8'h0f;
    localparam logic [7:0] NIB_HI_MASK = 8'hf0;
    localparam logic [7:0] SECOND_MASK = 8'h0c;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [PRESS_W-1:0] t_press;

    typedef struct packed {
        t_coord first_x;
        t_coord first_y;
        t_press first_pressure;
        logic   second_present;
        t_coord second_x;
        t_coord second_y;
        t_press second_pressure;
    } t_report;

    localparam int REPORT_W = $bits(t_report);

endpackage
`default_nettype wire

/* src/trjf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trjf_front: report frame decoder
// Accept a raw 16-byte frame and unpack both contacts into a report record.
// ----------------------------------------------------------------------------
module trjf_front (
    input  wire logic                             i_s_axis_tvalid,
    input  wire logic [trjf_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  wire logic                             i_queue_ready,
    output logic                                  o_push,
    output trjf_pkg::t_report                     o_report
);
    import trjf_pkg::*;

    logic [FRAME_W-1:0] w_lo;
    logic [FRAME_W-1:0] w_hi;
    logic [7:0] w_b1, w_b2, w_b3, w_b4, w_b6, w_b7, w_b8, w_b9, w_b11;
    logic [7:0] w_b4_lo, w_b4_hi, w_b9_lo, w_b9_hi, w_b1_sec;

    assign w_lo = i_s_axis_tdata[FRAME_W-1:0];
    assign w_hi = i_s_axis_tdata[S_TDATA_W-1:FRAME_W];

    assign w_b1  = w_lo[15:8];
    assign w_b2  = w_lo[23:16];
    assign w_b3  = w_lo[31:24];
    assign w_b4  = w_lo[39:32];
    assign w_b6  = w_lo[55:48];
    assign w_b7  = w_lo[63:56];
    assign w_b8  = w_hi[7:0];
    assign w_b9  = w_hi[15:8];
    assign w_b11 = w_hi[31:24];

    assign w_b4_lo  = w_b4 & NIB_LO_MASK;
    assign w_b4_hi  = w_b4 & NIB_HI_MASK;
    assign w_b9_lo  = w_b9 & NIB_LO_MASK;
    assign w_b9_hi  = w_b9 & NIB_HI_MASK;
    assign w_b1_sec = w_b1 & SECOND_MASK;

    always_comb begin
        o_report.first_x         = {w_b2, w_b4_lo[3:0]} & COORD_MASK;
        o_report.first_y         = {w_b3, w_b4_hi[7:4]} & COORD_MASK;
        o_report.first_pressure  = w_b6;
        o_report.second_present  = (w_b1_sec != 8'd0);
        o_report.second_x        = {w_b7, w_b9_lo[3:0]} & COORD_MASK;
        o_report.second_y        = {w_b8, w_b9_hi[7:4]} & COORD_MASK;
        o_report.second_pressure = w_b11;
    end

    // Push on every accepted word.
    assign o_push = i_s_axis_tvalid && i_queue_ready;

endmodule
`default_nettype wire

/* src/trjf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trjf_queue: decoded report queue
// Small register FIFO between decoder and filter.
// ----------------------------------------------------------------------------
module trjf_queue #(
    parameter int WIDTH = trjf_pkg::REPORT_W,
    parameter int DEPTH = trjf_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* src/trjf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trjf_back: drift filter and output stage
// Compare the head report against the reference positions, drop or emit it.
// ----------------------------------------------------------------------------
module trjf_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire trjf_pkg::t_coord               i_drift_threshold,
    input  wire logic                           i_head_valid,
    input  wire trjf_pkg::t_report              i_head,
    output logic                                o_pop,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [trjf_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                o_m_axis_tuser
);
    import trjf_pkg::*;

    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_coord  r_ref_fx, r_ref_fy, r_ref_sx, r_ref_sy;
    t_coord  n_ref_fx, n_ref_fy, n_ref_sx, n_ref_sy;
    t_report r_out, n_out;
    logic    r_out_valid, n_out_valid;

    logic w_still1, w_still2, w_drop, w_load_ok, w_emit;

    assign w_still1 = (abs_diff(r_ref_fx, i_head.first_x) < i_drift_threshold) &&
                      (abs_diff(r_ref_fy, i_head.first_y) < i_drift_threshold) &&
                      (i_head.first_pressure != '0);
    assign w_still2 = !i_head.second_present ||
                      ((abs_diff(r_ref_sx, i_head.second_x) < i_drift_threshold) &&
                       (abs_diff(r_ref_sy, i_head.second_y) < i_drift_threshold));
    assign w_drop    = w_still1 && w_still2;
    assign w_load_ok = !r_out_valid || i_m_axis_tready;
    assign o_pop     = i_head_valid && (w_drop || w_load_ok);
    assign w_emit    = o_pop && !w_drop;

    always_comb begin
        n_ref_fx    = r_ref_fx;
        n_ref_fy    = r_ref_fy;
        n_ref_sx    = r_ref_sx;
        n_ref_sy    = r_ref_sy;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (w_emit) begin
            if (i_head.first_pressure == '0) begin
                n_ref_fx = '0;
                n_ref_fy = '0;
                n_ref_sx = '0;
                n_ref_sy = '0;
            end else begin
                n_ref_fx = i_head.first_x;
                n_ref_fy = i_head.first_y;
                if (i_head.second_present) begin
                    n_ref_sx = i_head.second_x;
                    n_ref_sy = i_head.second_y;
                end
            end
            n_out = i_head;
            if (!i_head.second_present) begin
                n_out.second_x        = '0;
                n_out.second_y        = '0;
                n_out.second_pressure = '0;
            end
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_fx    <= '0;
            r_ref_fy    <= '0;
            r_ref_sx    <= '0;
            r_ref_sy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ref_fx    <= n_ref_fx;
            r_ref_fy    <= n_ref_fy;
            r_ref_sx    <= n_ref_sx;
            r_ref_sy    <= n_ref_sy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.second_present;
    assign o_m_axis_tdata  = {r_out.second_pressure, r_out.second_y, r_out.second_x,
                              r_out.first_pressure, r_out.first_y, r_out.first_x};

endmodule
`default_nettype wire

/* src/touch_report_jitter_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_report_jitter_filter: two-contact touch report decoder and filter
// Decode touch report frames and drop those whose contacts did not move.
// ----------------------------------------------------------------------------
// Takes one 16-byte touch report word per cycle on the slave stream and
// unpacks 12-bit X/Y and pressure for two contacts. A report is dropped when
// the first contact moved less than the drift threshold on both axes (with
// nonzero pressure) and the second contact is absent or also below it;
// otherwise it goes out on the master stream and becomes the new reference.
// Zero first pressure always emits and clears all references. Throughput is
// one word per cycle while the queue has room and the output is not stalled,
// set by the combinational compare and registered reference update in the
// filter stage. An emitted report passes through the queue and then into the
// output register, which drives the master tvalid.
// Write the threshold only while the block is idle.
// ----------------------------------------------------------------------------
module touch_report_jitter_filter #(
    parameter int QUEUE_DEPTH = trjf_pkg::QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Threshold register
    input  wire logic                             i_cfg_we,
    input  wire logic [trjf_pkg::COORD_W-1:0]     i_cfg_wdata,
    // Report frames in
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [63:0] frame_low, [127:64] frame_high
    input  wire logic [trjf_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // Filtered reports out
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [11:0] first_x, [23:12] first_y, [31:24] first_pressure,
    // [43:32] second_x, [55:44] second_y, [63:56] second_pressure
    output logic [trjf_pkg::M_TDATA_W-1:0]        o_m_axis_tdata,
    // [0] second_present
    output logic                                  o_m_axis_tuser
);
    import trjf_pkg::*;

    t_coord  r_drift_threshold;
    logic    w_push, w_queue_ready, w_head_valid, w_pop;
    t_report w_report, w_head;

    // Hold the threshold; reset leaves it at zero so every report passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift_threshold <= '0;
        end else if (i_cfg_we) begin
            r_drift_threshold <= i_cfg_wdata;
        end
    end

    // Decode the frame and push it whenever the queue has room.
    trjf_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_queue_ready   (w_queue_ready),
        .o_push          (w_push),
        .o_report        (w_report)
    );

    assign o_s_axis_tready = w_queue_ready;

    // Decouple the decoder from the filter so each side can stall alone.
    trjf_queue #(
        .WIDTH (REPORT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_report),
        .o_ready (w_queue_ready),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    // Filter against the references; drop duplicates without waiting on
    // the output, and advance emitted reports into the output register.
    trjf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_drift_threshold (r_drift_threshold),
        .i_head_valid      (w_head_valid),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_m_axis_tvalid   (o_m_axis_tvalid),
        .i_m_axis_tready   (i_m_axis_tready),
        .o_m_axis_tdata    (o_m_axis_tdata),
        .o_m_axis_tuser    (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

/* src/trjf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trjf_checker: port-level checks
// Watch the streams of the jitter filter over time.
// ----------------------------------------------------------------------------
module trjf_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             o_s_axis_tready,
    input  wire logic                             o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    input  wire logic [trjf_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  wire logic                             o_m_axis_tuser
);
    // A stalled output word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    // Reset empties the output stage.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Reset empties the queue, so input is taken right after.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // An absent second contact carries zero second fields.
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[63:32] == 32'd0)
        else $error("second contact fields nonzero while absent");

endmodule

bind touch_report_jitter_filter trjf_checker u_trjf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
